@@ hw/rtl/vxhm_pkg.sv @@
// shared types and constants for the voxel store with column heightmap
// used by vxhm_ctrl, vxhm_dp and voxel_store_with_column_heightmap_top
`default_nettype none

package vxhm_pkg;

    localparam int COORD_W   = 11;
    localparam int TILE_W    = 8;
    localparam int TOP_OUT_W = 5;

    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_SET   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear;     // write air / zero at the sweep address
        logic capture;   // latch the incoming item
        logic look;      // read tile and column top at the item position
        logic fetch;     // take the read data
        logic write;     // write the new tile id
        logic scan;      // walk the column downward
        logic load_out;  // fill the result register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic in_range;
        logic is_set;
        logic scan_done;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/voxel_store_with_column_heightmap_top.sv @@
// top level of the voxel store with column heightmap
// instantiates vxhm_ctrl and vxhm_dp, types from vxhm_pkg
//
//  channel | signals                                   | direction
//  req     | req_valid, req_stall, cmd, coord_x/y/z,   | in (stall out)
//          | tile_value                                |
//  rsp     | rsp_valid, rsp_stall, in_range, tile_read,| out (stall in)
//          | solid, dark, column_top, previous_top,    |
//          | top_changed                               |
//
// probe: look, fetch and finish states lead to the result; outside the grid: look, finish
// set: look, fetch, write, a column scan and finish lead to the result, the column scan
// reading one y per cycle from the top down through the tile memory read port
// after reset a clearing pass over every tile memory word zeroes both memories;
// req_stall stays high during it
// one item at a time; the next item is taken while a result waits under rsp_stall
`default_nettype none

module voxel_store_with_column_heightmap_top #(
    parameter int SIZE_X = 64,
    parameter int SIZE_Y = 32,
    parameter int SIZE_Z = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 req_valid,
    output logic                                      req_stall,
    input  wire logic                                 cmd,
    input  wire logic signed [vxhm_pkg::COORD_W-1:0]  coord_x,
    input  wire logic signed [vxhm_pkg::COORD_W-1:0]  coord_y,
    input  wire logic signed [vxhm_pkg::COORD_W-1:0]  coord_z,
    input  wire logic [vxhm_pkg::TILE_W-1:0]          tile_value,
    output logic                                      rsp_valid,
    input  wire logic                                 rsp_stall,
    output logic                                      in_range,
    output logic [vxhm_pkg::TILE_W-1:0]               tile_read,
    output logic                                      solid,
    output logic                                      dark,
    output logic [vxhm_pkg::TOP_OUT_W-1:0]            column_top,
    output logic [vxhm_pkg::TOP_OUT_W-1:0]            previous_top,
    output logic                                      top_changed
);

    vxhm_pkg::dp_cmd_t  dp_cmd;
    vxhm_pkg::dp_stat_t dp_stat;

    vxhm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    vxhm_dp #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat),
        .cmd          (cmd),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .tile_value   (tile_value),
        .in_range     (in_range),
        .tile_read    (tile_read),
        .solid        (solid),
        .dark         (dark),
        .column_top   (column_top),
        .previous_top (previous_top),
        .top_changed  (top_changed)
    );

    // the tile memory is never written for an item outside the grid
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.write |-> dp_stat.in_range)
        else $error("tile write for an item outside the grid");

    // an accepted item stalls the request in the cycle after it
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("second item accepted right behind the first");

    // a result outside the grid carries nothing
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !in_range) |-> (tile_read == '0 && column_top == '0
            && previous_top == '0 && !solid && !dark && !top_changed))
        else $error("result outside the grid is not all zero");

    // a probe never moves the column top
    a_probe_keeps_top: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out && !dp_stat.is_set |=> (column_top == previous_top && !top_changed))
        else $error("probe changed the column top");

endmodule

`default_nettype wire

@@ hw/rtl/vxhm_ctrl.sv @@
// controller state machine for the voxel store
// depends on vxhm_pkg for the command and status structs
`default_nettype none

module vxhm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output vxhm_pkg::dp_cmd_t       dp_cmd,
    input  wire vxhm_pkg::dp_stat_t dp_stat
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_LOOK   = 7'b0000100,
        ST_FETCH  = 7'b0001000,
        ST_WRITE  = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                dp_cmd.clear = 1'b1;
                if (dp_stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                dp_cmd.look = 1'b1;
                state_next  = dp_stat.in_range ? ST_FETCH : ST_FINISH;
            end
            ST_FETCH:
            begin
                dp_cmd.fetch = 1'b1;
                state_next   = dp_stat.is_set ? ST_WRITE : ST_FINISH;
            end
            ST_WRITE:
            begin
                dp_cmd.write = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                dp_cmd.scan = 1'b1;
                if (dp_stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait until the result register is free or being emptied
                if (!out_valid_reg || !rsp_stall)
                begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dp_cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/vxhm_dp.sv @@
// datapath: tile memory, column top memory, column scan and result register
// depends on vxhm_pkg; driven by vxhm_ctrl
`default_nettype none

module vxhm_dp #(
    parameter int SIZE_X = 64,
    parameter int SIZE_Y = 32,
    parameter int SIZE_Z = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire vxhm_pkg::dp_cmd_t                    dp_cmd,
    output vxhm_pkg::dp_stat_t                        dp_stat,
    input  wire logic                                 cmd,
    input  wire logic signed [vxhm_pkg::COORD_W-1:0]  coord_x,
    input  wire logic signed [vxhm_pkg::COORD_W-1:0]  coord_y,
    input  wire logic signed [vxhm_pkg::COORD_W-1:0]  coord_z,
    input  wire logic [vxhm_pkg::TILE_W-1:0]          tile_value,
    output logic                                      in_range,
    output logic [vxhm_pkg::TILE_W-1:0]               tile_read,
    output logic                                      solid,
    output logic                                      dark,
    output logic [vxhm_pkg::TOP_OUT_W-1:0]            column_top,
    output logic [vxhm_pkg::TOP_OUT_W-1:0]            previous_top,
    output logic                                      top_changed
);

    localparam int CW  = vxhm_pkg::COORD_W;
    localparam int TW  = vxhm_pkg::TILE_W;
    localparam int OW  = vxhm_pkg::TOP_OUT_W;
    localparam int XW  = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
    localparam int YW  = $clog2(SIZE_Y);
    localparam int ZW  = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
    localparam int CAW = XW + ZW;
    localparam int AW  = YW + CAW;
    localparam int VOX_DEPTH = 1 << AW;
    localparam int COL_DEPTH = 1 << CAW;
    localparam logic [CW-1:0] LIM_X = CW'(SIZE_X);
    localparam logic [CW-1:0] LIM_Y = CW'(SIZE_Y);
    localparam logic [CW-1:0] LIM_Z = CW'(SIZE_Z);
    localparam logic [YW-1:0] Y_TOP = YW'(SIZE_Y - 1);

    logic [TW-1:0] tile_mem [0:VOX_DEPTH-1];
    logic [YW-1:0] col_mem  [0:COL_DEPTH-1];

    logic                 cmd_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;
    logic [TW-1:0]        val_reg;
    logic                 range_reg;
    logic [TW-1:0]        tile_q_reg;
    logic [YW-1:0]        col_q_reg;
    logic [TW-1:0]        tile_reg;
    logic [YW-1:0]        prev_reg;
    logic [YW-1:0]        top_reg;
    logic [YW-1:0]        scan_y_reg;
    logic [YW-1:0]        chk_y_reg;
    logic                 chk_vld_reg;
    logic [AW-1:0]        clr_cnt_reg;

    logic [XW-1:0]  ax;
    logic [YW-1:0]  ay;
    logic [ZW-1:0]  az;
    logic [CAW-1:0] col_addr;
    logic [AW-1:0]  vox_addr;
    logic [AW-1:0]  rd_addr;
    logic           tile_we;
    logic [AW-1:0]  tile_wa;
    logic [TW-1:0]  tile_wd;
    logic           col_we;
    logic [CAW-1:0] col_wa;
    logic [YW-1:0]  col_wd;
    logic           scan_done;
    logic           range_in;
    logic [YW+OW-1:0] top_ext;
    logic [YW+OW-1:0] prev_ext;

    // a coordinate is inside when its sign is clear and it stays below the size
    assign range_in = !coord_x[CW-1] && ({1'b0, coord_x[CW-2:0]} < LIM_X)
                   && !coord_y[CW-1] && ({1'b0, coord_y[CW-2:0]} < LIM_Y)
                   && !coord_z[CW-1] && ({1'b0, coord_z[CW-2:0]} < LIM_Z);

    assign ax       = x_reg[XW-1:0];
    assign ay       = y_reg[YW-1:0];
    assign az       = z_reg[ZW-1:0];
    assign col_addr = {az, ax};
    assign vox_addr = {ay, az, ax};
    assign rd_addr  = dp_cmd.scan ? {scan_y_reg, az, ax} : vox_addr;

    // read data of the scan is registered and arrives in the cycle after its address
    assign scan_done = chk_vld_reg && ((tile_q_reg != '0) || (chk_y_reg == '0));

    assign tile_we = dp_cmd.clear || dp_cmd.write;
    assign tile_wa = dp_cmd.clear ? clr_cnt_reg : vox_addr;
    assign tile_wd = dp_cmd.clear ? '0 : val_reg;
    assign col_we  = dp_cmd.clear || (dp_cmd.scan && scan_done);
    assign col_wa  = dp_cmd.clear ? clr_cnt_reg[CAW-1:0] : col_addr;
    assign col_wd  = dp_cmd.clear ? '0 : chk_y_reg;

    always_ff @(posedge clk)
    begin
        if (tile_we)
        begin
            tile_mem[tile_wa] <= tile_wd;
        end
        tile_q_reg <= tile_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[col_wa] <= col_wd;
        end
        col_q_reg <= col_mem[col_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            if (dp_cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            chk_vld_reg <= dp_cmd.scan;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg   <= cmd;
            x_reg     <= coord_x;
            y_reg     <= coord_y;
            z_reg     <= coord_z;
            val_reg   <= tile_value;
            range_reg <= range_in;
        end
        if (dp_cmd.fetch)
        begin
            prev_reg <= col_q_reg;
            top_reg  <= col_q_reg;
            tile_reg <= tile_q_reg;
        end
        if (dp_cmd.write)
        begin
            tile_reg   <= val_reg;
            scan_y_reg <= Y_TOP;
        end
        if (dp_cmd.scan)
        begin
            chk_y_reg <= scan_y_reg;
            if (scan_y_reg != '0)
            begin
                scan_y_reg <= scan_y_reg - YW'(1);
            end
            if (scan_done)
            begin
                top_reg <= chk_y_reg;
            end
        end
    end

    assign top_ext  = {{OW{1'b0}}, top_reg};
    assign prev_ext = {{OW{1'b0}}, prev_reg};

    // outside the grid every field reads zero
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_out)
        begin
            in_range     <= range_reg;
            tile_read    <= range_reg ? tile_reg : '0;
            solid        <= range_reg && (tile_reg != '0);
            dark         <= range_reg && (ay < top_reg);
            column_top   <= range_reg ? top_ext[OW-1:0] : '0;
            previous_top <= range_reg ? prev_ext[OW-1:0] : '0;
            top_changed  <= range_reg && (cmd_reg == vxhm_pkg::CMD_SET)
                            && (top_reg != prev_reg);
        end
    end

    assign dp_stat.clear_last = &clr_cnt_reg;
    assign dp_stat.in_range   = range_reg;
    assign dp_stat.is_set     = (cmd_reg == vxhm_pkg::CMD_SET);
    assign dp_stat.scan_done  = scan_done;

endmodule

`default_nettype wire
